FILE: rtl/poil_pkg.sv
// ============================================================================
// poil_pkg
// Shared types, constants and helpers for the packed ordered item list.
// ============================================================================
package poil_pkg;

    localparam int MAX_ENTRIES    = 64;
    localparam int MAX_ITEM_BYTES = 8;
    localparam int IDX_W          = $clog2(MAX_ENTRIES);
    localparam int CNT_W          = IDX_W + 1;
    localparam int DATA_W         = 64;
    localparam int ACT_W          = 3;
    localparam int FOUND_W        = 8;
    localparam int BYTES_W        = 4;
    localparam int CFG_W          = 7;

    localparam logic [FOUND_W-1:0] NOT_FOUND = 8'hff;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_MODIFY = 3'd2,
        ACT_SEARCH = 3'd3,
        ACT_READ   = 3'd4,
        ACT_CLEAR  = 3'd5
    } action_t;

    typedef enum logic {
        REG_ITEM_BYTES  = 1'b0,
        REG_ENTRY_LIMIT = 1'b1
    } reg_index_t;

    // Byte mask for the live item size; size 0 acts as 1, above max acts as max.
    function automatic logic [DATA_W-1:0] item_mask(input logic [BYTES_W-1:0] bytes);
        logic [BYTES_W-1:0] b;
        logic [DATA_W-1:0]  m;
        b = bytes;
        if (b < BYTES_W'(1))
        begin
            b = BYTES_W'(1);
        end
        if (b > BYTES_W'(MAX_ITEM_BYTES))
        begin
            b = BYTES_W'(MAX_ITEM_BYTES);
        end
        m = '0;
        for (int i = 0; i < MAX_ITEM_BYTES; i++)
        begin
            if (BYTES_W'(i) < b)
            begin
                m[8*i +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

FILE: rtl/poil_ifs.sv
// ============================================================================
// poil_ifs
// Request and response channels of the packed ordered item list.
// ============================================================================
interface poil_req_if;
    logic                            valid;
    logic                            ready;
    logic [poil_pkg::ACT_W-1:0]      action;
    logic [poil_pkg::IDX_W-1:0]      position;
    logic [poil_pkg::DATA_W-1:0]     item_data;

    modport source (output valid, action, position, item_data, input ready);
    modport sink   (input valid, action, position, item_data, output ready);
endinterface

interface poil_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            ok;
    logic [poil_pkg::FOUND_W-1:0]    found_position;
    logic [poil_pkg::DATA_W-1:0]     read_data;
    logic [poil_pkg::CNT_W-1:0]      item_count;

    modport source (output valid, ok, found_position, read_data, item_count, input ready);
    modport sink   (input valid, ok, found_position, read_data, item_count, output ready);
endinterface

FILE: rtl/packed_ordered_item_list.sv
// ============================================================================
// packed_ordered_item_list
// Ordered, gap-free list of up to 64 items kept in one synchronous RAM.
// ============================================================================
// One request is taken at a time and gives one response beat. Append, modify,
// clear and failing requests go straight to the response state; read passes
// through a read state first. Search walks the RAM one entry per cycle from
// index 0; delete moves each later entry down one per cycle. The single RAM
// read port, whose read data is registered, paces these steps. A finished
// response waits in an output register, and the next request may be accepted
// while it is pending. Write configuration only while the block is idle; a
// write takes effect at the next edge.
module packed_ordered_item_list (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [poil_pkg::CFG_W-1:0]     cfg_data,
    poil_req_if.sink                       req,
    poil_rsp_if.source                     rsp
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_SHIFT  = 5'b00100,
        ST_READ   = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    localparam int IW = poil_pkg::IDX_W;
    localparam int CW = poil_pkg::CNT_W;
    localparam int DW = poil_pkg::DATA_W;

    logic [DW-1:0] mem [poil_pkg::MAX_ENTRIES];
    logic [DW-1:0] rd_data_reg;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [IW-1:0]                   idx_reg, idx_next;
    logic [DW-1:0]                   key_reg, key_next;
    logic                            res_ok_reg, res_ok_next;
    logic [poil_pkg::FOUND_W-1:0]    res_found_reg, res_found_next;
    logic [DW-1:0]                   res_data_reg, res_data_next;
    logic [poil_pkg::BYTES_W-1:0]    item_bytes_reg;
    logic [poil_pkg::CFG_W-1:0]      entry_limit_reg;

    logic                            out_valid_reg;
    logic                            out_ok_reg;
    logic [poil_pkg::FOUND_W-1:0]    out_found_reg;
    logic [DW-1:0]                   out_data_reg;
    logic [CW-1:0]                   out_count_reg;

    logic                            mem_we;
    logic [IW-1:0]                   mem_waddr;
    logic [DW-1:0]                   mem_wdata;
    logic [IW-1:0]                   rd_addr;
    logic [DW-1:0]                   mask;
    logic                            in_range;
    logic                            out_load;
    poil_pkg::action_t               act;

    assign mask     = poil_pkg::item_mask(item_bytes_reg);
    assign in_range = {1'b0, req.position} < cnt_reg;
    assign act      = poil_pkg::action_t'(req.action);
    assign req.ready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_RESP) && (!out_valid_reg || rsp.ready);

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_ok_reg;
    assign rsp.found_position = out_found_reg;
    assign rsp.read_data      = out_data_reg;
    assign rsp.item_count     = out_count_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        res_ok_next    = res_ok_reg;
        res_found_next = res_found_reg;
        res_data_next  = res_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = rd_data_reg;
        rd_addr        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    key_next       = req.item_data;
                    res_ok_next    = 1'b0;
                    res_found_next = poil_pkg::NOT_FOUND;
                    res_data_next  = '0;
                    state_next     = ST_RESP;
                    unique case (act)
                        poil_pkg::ACT_APPEND:
                        begin
                            if ((cnt_reg < entry_limit_reg) &&
                                (cnt_reg < CW'(poil_pkg::MAX_ENTRIES)))
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = cnt_reg[IW-1:0];
                                mem_wdata   = req.item_data & mask;
                                cnt_next    = cnt_reg + CW'(1);
                                res_ok_next = 1'b1;
                            end
                        end
                        poil_pkg::ACT_DELETE:
                        begin
                            if (in_range)
                            begin
                                res_ok_next = 1'b1;
                                if (({1'b0, req.position} + CW'(1)) < cnt_reg)
                                begin
                                    idx_next   = req.position;
                                    rd_addr    = req.position + IW'(1);
                                    state_next = ST_SHIFT;
                                end
                                else
                                begin
                                    cnt_next = cnt_reg - CW'(1);
                                end
                            end
                        end
                        poil_pkg::ACT_MODIFY:
                        begin
                            if (in_range)
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = req.position;
                                mem_wdata   = req.item_data & mask;
                                res_ok_next = 1'b1;
                            end
                        end
                        poil_pkg::ACT_SEARCH:
                        begin
                            if (cnt_reg != '0)
                            begin
                                idx_next   = '0;
                                rd_addr    = '0;
                                state_next = ST_SEARCH;
                            end
                        end
                        poil_pkg::ACT_READ:
                        begin
                            if (in_range)
                            begin
                                res_ok_next = 1'b1;
                                rd_addr     = req.position;
                                state_next  = ST_READ;
                            end
                        end
                        poil_pkg::ACT_CLEAR:
                        begin
                            cnt_next    = '0;
                            res_ok_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (((rd_data_reg ^ key_reg) & mask) == '0)
                begin
                    res_found_next = poil_pkg::FOUND_W'(idx_reg);
                    res_ok_next    = 1'b1;
                    state_next     = ST_RESP;
                end
                else if (({1'b0, idx_reg} + CW'(1)) >= cnt_reg)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                    rd_addr  = idx_reg + IW'(1);
                end
            end
            ST_SHIFT:
            begin
                mem_we = 1'b1;
                if (({1'b0, idx_reg} + CW'(2)) < cnt_reg)
                begin
                    idx_next = idx_reg + IW'(1);
                    rd_addr  = idx_reg + IW'(2);
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = ST_RESP;
                end
            end
            ST_READ:
            begin
                res_data_next = rd_data_reg & mask;
                state_next    = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            item_bytes_reg  <= poil_pkg::BYTES_W'(poil_pkg::MAX_ITEM_BYTES);
            entry_limit_reg <= poil_pkg::CFG_W'(poil_pkg::MAX_ENTRIES);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                unique case (poil_pkg::reg_index_t'(cfg_index))
                    poil_pkg::REG_ITEM_BYTES:  item_bytes_reg  <= cfg_data[poil_pkg::BYTES_W-1:0];
                    poil_pkg::REG_ENTRY_LIMIT: entry_limit_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        key_reg       <= key_next;
        res_ok_reg    <= res_ok_next;
        res_found_reg <= res_found_next;
        res_data_reg  <= res_data_next;
        if (out_load)
        begin
            out_ok_reg    <= res_ok_reg;
            out_found_reg <= res_found_reg;
            out_data_reg  <= res_data_reg;
            out_count_reg <= cnt_reg;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(poil_pkg::MAX_ENTRIES))
        else $error("item count above capacity");

    a_beat_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("response beat raised outside response state");

    a_shift_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (({1'b0, idx_reg} + CW'(1)) < cnt_reg))
        else $error("shift source beyond list tail");

    a_search_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> ({1'b0, idx_reg} < cnt_reg))
        else $error("search index beyond list tail");

endmodule

FILE: tb/tb_packed_ordered_item_list.sv
// ============================================================================
// tb_packed_ordered_item_list
// Self-checking bench for the packed ordered item list. Requests go in one at
// a time through a bursty sender. Each accepted beat runs through a local
// copy of the list, which queues the reply it should give. A monitor matches
// every reply beat, field by field, against the oldest queued reply. The run
// covers directed cases for every action, changes of item size and entry
// limit (extremes included), random traffic in several settings, and one long
// reply hold-off that backs the block up.
// ============================================================================
module tb_packed_ordered_item_list;
    timeunit 1ns;
    timeprecision 1ps;

    import poil_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNDEF_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNDEF_HI = 3'd7;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 170;

    typedef struct packed {
        logic               ok;
        logic [FOUND_W-1:0] found;
        logic [DATA_W-1:0]  rd;
        logic [CNT_W-1:0]   cnt;
    } list_reply_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    poil_req_if req_ch();
    poil_rsp_if rsp_ch();

    packed_ordered_item_list u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    logic [DATA_W-1:0] list_entries [MAX_ENTRIES];
    int list_count;
    int cfg_bytes;
    int cfg_limit;

    list_reply_t outstanding_replies[$];
    int mismatches = 0;

    int gap_max = 0;
    int burst_max = 6;
    int burst_left = 0;
    int rsp_mode = 0;
    int rsp_hold_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(8_000_000);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [DATA_W-1:0] size_mask();
        int b;
        b = cfg_bytes;
        if (b < 1)
        begin
            b = 1;
        end
        if (b >= MAX_ITEM_BYTES)
        begin
            return '1;
        end
        return (64'h1 << (8 * b)) - 64'h1;
    endfunction

    function automatic int eff_limit();
        return (cfg_limit > MAX_ENTRIES) ? MAX_ENTRIES : cfg_limit;
    endfunction

    function automatic list_reply_t predict_reply(input logic [ACT_W-1:0] act,
                                                  input logic [IDX_W-1:0] pos,
                                                  input logic [DATA_W-1:0] data);
        list_reply_t r;
        logic [DATA_W-1:0] m;
        logic in_range;
        m = size_mask();
        r.ok = 1'b0;
        r.found = NOT_FOUND;
        r.rd = '0;
        in_range = int'(pos) < list_count;
        case (act)
            ACT_APPEND:
            begin
                if (list_count < eff_limit())
                begin
                    list_entries[list_count] = data & m;
                    list_count++;
                    r.ok = 1'b1;
                end
            end
            ACT_DELETE:
            begin
                if (in_range)
                begin
                    for (int i = int'(pos); i < list_count - 1; i++)
                    begin
                        list_entries[i] = list_entries[i + 1];
                    end
                    list_count--;
                    r.ok = 1'b1;
                end
            end
            ACT_MODIFY:
            begin
                if (in_range)
                begin
                    list_entries[pos] = data & m;
                    r.ok = 1'b1;
                end
            end
            ACT_SEARCH:
            begin
                for (int i = 0; i < list_count; i++)
                begin
                    if (!r.ok && ((list_entries[i] ^ data) & m) == '0)
                    begin
                        r.found = FOUND_W'(i);
                        r.ok = 1'b1;
                    end
                end
            end
            ACT_READ:
            begin
                if (in_range)
                begin
                    r.rd = list_entries[pos] & m;
                    r.ok = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                list_count = 0;
                r.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.cnt = CNT_W'(list_count);
        return r;
    endfunction

    task automatic send_req(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] pos,
                            input logic [DATA_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.position  <= pos;
        req_ch.item_data <= data;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        outstanding_replies.push_back(predict_reply(act, pos, data));
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (outstanding_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_ITEM_BYTES)
        begin
            cfg_bytes = int'(val[BYTES_W-1:0]);
        end
        else
        begin
            cfg_limit = int'(val);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_request();
        logic [ACT_W-1:0] act;
        logic [IDX_W-1:0] pos;
        logic [DATA_W-1:0] data;
        int pick;
        int app_w;
        app_w = (list_count * 2 < eff_limit()) ? 40 : 22;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            act = ACT_CLEAR;
        else if (pick < 5)
            act = ($urandom_range(0, 1) != 0) ? ACT_UNDEF_HI : ACT_UNDEF_LO;
        else if (pick < 5 + app_w)
            act = ACT_APPEND;
        else if (pick < 23 + app_w)
            act = ACT_DELETE;
        else if (pick < 35 + app_w)
            act = ACT_MODIFY;
        else if (pick < 52 + app_w)
            act = ACT_SEARCH;
        else
            act = ACT_READ;

        pick = $urandom_range(0, 9);
        if (list_count > 0 && pick < 8)
            pos = IDX_W'($urandom_range(0, list_count - 1));
        else if (pick == 8 && list_count < MAX_ENTRIES)
            pos = IDX_W'(list_count);
        else
            pos = IDX_W'($urandom_range(0, MAX_ENTRIES - 1));

        pick = $urandom_range(0, 9);
        if (act == ACT_SEARCH && list_count > 0 && pick < 6)
            pick = 2;
        if (pick == 0)
            data = '0;
        else if (pick == 1)
            data = '1;
        else if (pick == 2 && list_count > 0)
            data = list_entries[$urandom_range(0, list_count - 1)]
                   | ({$urandom, $urandom} & ~size_mask());
        else
            data = {$urandom, $urandom};
        send_req(act, pos, data);
    endtask

    always @(posedge clk)
    begin
        list_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (outstanding_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("ERROR: reply beat with none pending, count %0d",
                             rsp_ch.item_count);
                end
            end
            else
            begin
                want = outstanding_replies.pop_front();
                if (rsp_ch.ok !== want.ok || rsp_ch.found_position !== want.found
                    || rsp_ch.read_data !== want.rd || rsp_ch.item_count !== want.cnt)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: ok %0b/%0b found %0d/%0d data %h/%h count %0d/%0d",
                                 want.ok, rsp_ch.ok, want.found, rsp_ch.found_position,
                                 want.rd, rsp_ch.read_data, want.cnt, rsp_ch.item_count);
                    end
                end
            end
        end
    end

    initial
    begin : reply_pacing
        int stall_left;
        int open_left;
        stall_left = 0;
        open_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (rsp_mode == 1)
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= 30);
            end
            else if (rsp_mode == 2)
            begin
                if (open_left > 0)
                begin
                    rsp_ch.ready <= 1'b1;
                    open_left--;
                end
                else
                begin
                    rsp_ch.ready <= 1'b0;
                    stall_left = $urandom_range(0, 6);
                    open_left = $urandom_range(1, 12);
                end
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic test_basic_actions();
        gap_max = 2;
        rsp_mode = 1;
        send_req(ACT_APPEND, 6'd0, 64'h0);
        send_req(ACT_APPEND, 6'd0, '1);
        send_req(ACT_APPEND, 6'd0, 64'h5555_5555_5555_5555);
        send_req(ACT_APPEND, 6'd0, 64'haaaa_aaaa_aaaa_aaaa);
        send_req(ACT_READ, 6'd0, 64'h0);
        send_req(ACT_READ, 6'd3, 64'h0);
        send_req(ACT_READ, 6'd63, 64'h0);
        send_req(ACT_SEARCH, 6'd0, 64'h5555_5555_5555_5555);
        send_req(ACT_SEARCH, 6'd0, 64'h0000_0000_0000_1234);
        send_req(ACT_MODIFY, 6'd1, 64'h0123_4567_89ab_cdef);
        send_req(ACT_MODIFY, 6'd63, '1);
        send_req(ACT_DELETE, 6'd0, 64'h0);
        send_req(ACT_DELETE, 6'd63, 64'h0);
        send_req(ACT_READ, 6'd0, 64'h0);
        send_req(ACT_UNDEF_LO, 6'd0, '1);
        send_req(ACT_UNDEF_HI, 6'd63, '1);
        send_req(ACT_CLEAR, 6'd0, 64'h0);
        send_req(ACT_READ, 6'd0, 64'h0);
        send_req(ACT_SEARCH, 6'd0, 64'h0);
        send_req(ACT_DELETE, 6'd0, 64'h0);
    endtask

    task automatic test_item_size_and_limit();
        write_reg(REG_ENTRY_LIMIT, 7'd1);
        send_req(ACT_APPEND, 6'd0, 64'h0);
        send_req(ACT_APPEND, 6'd0, 64'h1111_2222_3333_4444);
        write_reg(REG_ENTRY_LIMIT, 7'd64);
        send_req(ACT_APPEND, 6'd0, '1);
        write_reg(REG_ITEM_BYTES, 7'd2);
        send_req(ACT_READ, 6'd1, 64'h0);
        send_req(ACT_SEARCH, 6'd0, 64'hdead_beef_0000_ffff);
        send_req(ACT_APPEND, 6'd0, 64'hfedc_ba98_7654_3210);
        write_reg(REG_ITEM_BYTES, 7'd8);
        send_req(ACT_READ, 6'd2, 64'h0);
        write_reg(REG_ITEM_BYTES, 7'd0);
        send_req(ACT_SEARCH, 6'd0, 64'h0000_0000_0000_0010);
        write_reg(REG_ITEM_BYTES, 7'd15);
        send_req(ACT_READ, 6'd1, 64'h0);
        write_reg(REG_ENTRY_LIMIT, 7'd0);
        send_req(ACT_APPEND, 6'd0, 64'h0);
        write_reg(REG_ENTRY_LIMIT, 7'd127);
        send_req(ACT_APPEND, 6'd0, 64'h8000_0000_0000_0001);
        write_reg(REG_ENTRY_LIMIT, 7'd1);
        send_req(ACT_READ, 6'd3, 64'h0);
        send_req(ACT_APPEND, 6'd0, 64'h7);
    endtask

    task automatic test_random_traffic();
        int phase_bytes [PHASES] = '{8, 1, 0, 15, 3, 5, 2, 8};
        int phase_limit [PHASES] = '{64, 64, 5, 127, 1, 0, 33, 64};
        int phase_gap   [PHASES] = '{0, 3, 6, 2, 8, 1, 4, 0};
        int phase_rsp   [PHASES] = '{0, 1, 2, 1, 2, 0, 1, 2};
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_ITEM_BYTES, CFG_W'(phase_bytes[p]));
            write_reg(REG_ENTRY_LIMIT, CFG_W'(phase_limit[p]));
            gap_max = phase_gap[p];
            rsp_mode = phase_rsp[p];
            repeat (PHASE_ITEMS) send_random_request();
        end
    endtask

    task automatic test_reply_hold();
        wait_idle();
        gap_max = 0;
        rsp_mode = 0;
        rsp_hold_cycles = 300;
        repeat (24) send_random_request();
    endtask

    initial
    begin
        req_ch.valid     <= 1'b0;
        req_ch.action    <= ACT_APPEND;
        req_ch.position  <= '0;
        req_ch.item_data <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_ITEM_BYTES;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            list_entries[i] = '0;
        end
        list_count = 0;
        cfg_bytes = MAX_ITEM_BYTES;
        cfg_limit = MAX_ENTRIES;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_basic_actions();
        test_item_size_and_limit();
        test_random_traffic();
        test_reply_hold();

        rsp_mode = 0;
        wait_idle();
        repeat (80) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
